@@ rtl/salct_pkg.sv @@
// Shared types and constants of the set-associative LRU cache tag directory.
// Used by the controller, the datapath and the top level; depends on nothing.
package salct_pkg;

  // Directory geometry.
  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 32;
  localparam int SET_BITS   = $clog2(MAX_SETS);
  localparam int WAY_BITS   = $clog2(MAX_WAYS);
  localparam int RANK_BITS  = $clog2(MAX_WAYS);
  localparam int TAG_WIDTH  = ADDR_WIDTH;
  localparam int CNT_WIDTH  = 48;
  localparam int CFG_WIDTH  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int OP_WIDTH   = 2;
  localparam int SHIFT_W    = 5;

  // Access types.
  localparam logic [OP_WIDTH-1:0] OP_READ  = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_FETCH = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS         = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_WIDTH-1:0] BLOCK_OFFSET_RESET = 4'd5;
  localparam logic [CFG_WIDTH-1:0] SET_INDEX_RESET    = 4'd6;
  localparam logic [CFG_WIDTH-1:0] WAYS_RESET         = 4'd4;

  // Saturation limit of the statistics counters.
  localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

  // One set of the directory, stored as a single memory row.
  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] tag;
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0]                dirty;
    logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
  } row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Register the accepted access and start the set read.
    logic commit;   // Update the set, the counters and the result register.
  } ctrl_cmd_t;

endpackage

@@ rtl/salct_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// Holds the set rows of the cache tag directory; depends on nothing.
module salct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/salct_ctrl.sv @@
// Controller of the cache tag directory: sequences the read and the update
// of one set per access and owns both handshakes. Depends on salct_pkg.
module salct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output salct_pkg::ctrl_cmd_t  cmd
);

  localparam logic [0:0] ST_IDLE   = 1'b0;
  localparam logic [0:0] ST_LOOKUP = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       out_valid_next;

  // A new access is taken only while no set update is pending.
  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // The update waits until the result register is free or being emptied.
  assign cmd.commit  = (state == ST_LOOKUP) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result register occupancy.
  always_comb begin
    priority if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // An update always leaves a result waiting in the next cycle.
  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result missing after a set update");

  // A pending update with a blocked result stays pending.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) && out_valid && !out_ready |=> (state == ST_LOOKUP))
    else $error("set update left while the result register was full");

  // No second access is taken in the cycle after a capture.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("input taken while a set update was pending");

endmodule

@@ rtl/salct_dp.sv @@
// Datapath of the cache tag directory: address split, set memory, hit and
// victim selection, LRU update and statistics. Depends on salct_pkg, salct_ram.
module salct_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  salct_pkg::ctrl_cmd_t                  cmd,
  input  logic                                  cfg_write,
  input  logic [salct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [salct_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic [salct_pkg::ADDR_WIDTH-1:0]      address,
  input  logic [salct_pkg::OP_WIDTH-1:0]        operation,
  output logic                                  hit,
  output logic                                  writeback,
  output logic [salct_pkg::WAY_BITS-1:0]        way_used,
  output logic [salct_pkg::CNT_WIDTH-1:0]       total_accesses,
  output logic [salct_pkg::CNT_WIDTH-1:0]       total_hits,
  output logic [salct_pkg::CNT_WIDTH-1:0]       total_misses,
  output logic [salct_pkg::CNT_WIDTH-1:0]       total_writebacks
);

  localparam int SB = salct_pkg::SET_BITS;
  localparam int WB = salct_pkg::WAY_BITS;
  localparam int RB = salct_pkg::RANK_BITS;
  localparam int NW = salct_pkg::MAX_WAYS;
  localparam int CW = salct_pkg::CFG_WIDTH;

  // Configuration registers.
  logic [CW-1:0] block_offset_bits;
  logic [CW-1:0] set_index_bits;
  logic [CW-1:0] ways_in_use;

  // Captured access.
  logic [SB-1:0]                     set_q;
  logic [salct_pkg::TAG_WIDTH-1:0]   tag_q;
  logic                              is_write_q;
  logic                              row_init_q;

  // One flag per set: the row has been written since reset.
  logic [salct_pkg::MAX_SETS-1:0]    row_init;

  // Address split.
  logic [CW-1:0]                     sbits;
  logic [salct_pkg::SHIFT_W-1:0]     tag_shift;
  logic [SB:0]                       set_mask_wide;
  logic [salct_pkg::ADDR_WIDTH-1:0]  addr_shifted;
  logic [SB-1:0]                     set_in;
  logic [salct_pkg::TAG_WIDTH-1:0]   tag_in;

  // Set lookup and update.
  salct_pkg::row_t                   rd_row;
  salct_pkg::row_t                   cur_row;
  salct_pkg::row_t                   new_row;
  logic [CW-1:0]                     nways;
  logic [NW-1:0]                     way_en;
  logic                              any_hit;
  logic [WB-1:0]                     hit_way;
  logic                              any_free;
  logic [WB-1:0]                     free_way;
  logic [RB-1:0]                     best_rank;
  logic [WB-1:0]                     lru_way;
  logic [WB-1:0]                     sel_way;
  logic                              evict_dirty;
  logic [RB-1:0]                     sel_rank;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset_bits <= salct_pkg::BLOCK_OFFSET_RESET;
      set_index_bits    <= salct_pkg::SET_INDEX_RESET;
      ways_in_use       <= salct_pkg::WAYS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        salct_pkg::CFG_BLOCK_OFFSET: block_offset_bits <= cfg_data;
        salct_pkg::CFG_SET_INDEX:    set_index_bits    <= cfg_data;
        salct_pkg::CFG_WAYS:         ways_in_use       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Split the incoming address into set index and tag.
  always_comb begin
    if (set_index_bits > CW'(SB)) begin
      sbits = CW'(SB);
    end else begin
      sbits = set_index_bits;
    end
    tag_shift     = salct_pkg::SHIFT_W'(block_offset_bits) + salct_pkg::SHIFT_W'(sbits);
    set_mask_wide = ((SB+1)'(1) << sbits) - (SB+1)'(1);
    addr_shifted  = address >> block_offset_bits;
    set_in        = addr_shifted[SB-1:0] & set_mask_wide[SB-1:0];
    tag_in        = address >> tag_shift;
  end

  // Capture the access while its set row is read.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q      <= set_in;
      tag_q      <= tag_in;
      is_write_q <= (operation == salct_pkg::OP_WRITE);
      row_init_q <= row_init[set_in];
    end
  end

  salct_ram #(
    .WIDTH($bits(salct_pkg::row_t)),
    .DEPTH(salct_pkg::MAX_SETS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (set_q),
    .wr_data (new_row),
    .rd_en   (cmd.capture),
    .rd_addr (set_in),
    .rd_data (rd_row)
  );

  // A row never written reads as its reset contents.
  always_comb begin
    if (row_init_q) begin
      cur_row = rd_row;
    end else begin
      cur_row       = '0;
      for (int w = 0; w < NW; w++) begin
        cur_row.rank[w] = RB'(w);
      end
    end
  end

  // Ways in use, with zero acting as one and large values clamped.
  always_comb begin
    priority if (ways_in_use == '0) begin
      nways = CW'(1);
    end else if (ways_in_use > CW'(NW)) begin
      nways = CW'(NW);
    end else begin
      nways = ways_in_use;
    end
    for (int w = 0; w < NW; w++) begin
      way_en[w] = (CW'(w) < nways);
    end
  end

  // Hit search and first free way, lowest way number first.
  always_comb begin
    any_hit  = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (way_en[w] && cur_row.valid[w] && (cur_row.tag[w] == tag_q)) begin
        any_hit = 1'b1;
        hit_way = WB'(w);
      end
      if (way_en[w] && !cur_row.valid[w]) begin
        any_free = 1'b1;
        free_way = WB'(w);
      end
    end
  end

  // Least recently used way in use: the highest rank.
  always_comb begin
    best_rank = '0;
    lru_way   = '0;
    for (int w = 0; w < NW; w++) begin
      if (way_en[w] && (cur_row.rank[w] >= best_rank)) begin
        best_rank = cur_row.rank[w];
        lru_way   = WB'(w);
      end
    end
  end

  // Chosen way, eviction and the updated row.
  always_comb begin
    priority if (any_hit) begin
      sel_way = hit_way;
    end else if (any_free) begin
      sel_way = free_way;
    end else begin
      sel_way = lru_way;
    end
    evict_dirty = !any_hit && !any_free && cur_row.dirty[lru_way];
    sel_rank    = cur_row.rank[sel_way];

    new_row = cur_row;
    if (any_hit) begin
      if (is_write_q) begin
        new_row.dirty[sel_way] = 1'b1;
      end
    end else begin
      new_row.tag[sel_way]   = tag_q;
      new_row.valid[sel_way] = 1'b1;
      new_row.dirty[sel_way] = is_write_q;
    end
    // Move the chosen way to the front and age the ways ahead of it.
    for (int w = 0; w < NW; w++) begin
      if (WB'(w) == sel_way) begin
        new_row.rank[w] = '0;
      end else if (cur_row.rank[w] < sel_rank) begin
        new_row.rank[w] = cur_row.rank[w] + RB'(1);
      end
    end
  end

  // Row written flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (cmd.commit) begin
      row_init[set_q] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit       <= any_hit;
      writeback <= evict_dirty;
      way_used  <= sel_way;
    end
  end

  // Saturating statistics; they change only when a result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_accesses   <= '0;
      total_hits       <= '0;
      total_misses     <= '0;
      total_writebacks <= '0;
    end else if (cmd.commit) begin
      if (total_accesses != salct_pkg::CNT_MAX) begin
        total_accesses <= total_accesses + 1'b1;
      end
      if (any_hit && (total_hits != salct_pkg::CNT_MAX)) begin
        total_hits <= total_hits + 1'b1;
      end
      if (!any_hit && (total_misses != salct_pkg::CNT_MAX)) begin
        total_misses <= total_misses + 1'b1;
      end
      if (evict_dirty && (total_writebacks != salct_pkg::CNT_MAX)) begin
        total_writebacks <= total_writebacks + 1'b1;
      end
    end
  end

  // A hit never evicts anything.
  a_no_wb_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !(hit && writeback))
    else $error("writeback flagged on a hit");

  // A free way in the set means no eviction.
  a_free_no_evict: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && any_free |-> !evict_dirty)
    else $error("eviction while a free way existed");

  // The updated set is marked written.
  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> row_init[$past(set_q)])
    else $error("updated set not marked as written");

endmodule

@@ rtl/set_assoc_lru_cache_tags.sv @@
// Set-associative write-back cache tag directory with true LRU replacement.
// The accepted access and its set row are registered first; the result is then
// registered at the set update, and a result still held on the output delays
// that update until it is taken. No new access is taken until the last one's
// set row has had its read-modify-write through the single-read row memory.
// Reset clears the counters, restores the configuration and marks every set
// row as unwritten at once; no clearing pass is needed.
module set_assoc_lru_cache_tags (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [salct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salct_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [salct_pkg::ADDR_WIDTH-1:0]    address,
  input  logic [salct_pkg::OP_WIDTH-1:0]      operation,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic                                writeback,
  output logic [salct_pkg::WAY_BITS-1:0]      way_used,
  output logic [salct_pkg::CNT_WIDTH-1:0]     total_accesses,
  output logic [salct_pkg::CNT_WIDTH-1:0]     total_hits,
  output logic [salct_pkg::CNT_WIDTH-1:0]     total_misses,
  output logic [salct_pkg::CNT_WIDTH-1:0]     total_writebacks
);

  salct_pkg::ctrl_cmd_t cmd;

  // Sequencing and handshakes.
  salct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Directory storage, lookup and statistics.
  salct_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .address          (address),
    .operation        (operation),
    .hit              (hit),
    .writeback        (writeback),
    .way_used         (way_used),
    .total_accesses   (total_accesses),
    .total_hits       (total_hits),
    .total_misses     (total_misses),
    .total_writebacks (total_writebacks)
  );

endmodule
